// ----- rtl/quadtree_image_decoder_top_assert.svh -----
// Assertion helpers shared by the decoder modules.
`ifndef QUADTREE_IMAGE_DECODER_TOP_ASSERT_SVH
`define QUADTREE_IMAGE_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define QTD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qtd_pkg.sv -----
`timescale 1ns / 1ps

package qtd_pkg;

  localparam int SYM_W   = 8;
  localparam int COORD_W = 10;
  localparam int SIDE_W  = 11;
  localparam int SHIFT_W = 3;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd1024;

  localparam logic [SYM_W-1:0] SPLIT_CHAR = 8'd42;  // '*'
  localparam logic [SYM_W-1:0] DIGIT_LO   = 8'd48;  // '0'
  localparam logic [SYM_W-1:0] DIGIT_HI   = 8'd57;  // '9'

  // shared update control for the stack cell chain
  typedef struct packed {
    logic               en;
    logic [SHIFT_W-1:0] shift;  // entries pushed this cycle after the pop
  } cell_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] row_top;
    logic [COORD_W-1:0] col_left;
    logic [COORD_W-1:0] row_bottom;
    logic [COORD_W-1:0] col_right;
    logic [SYM_W-1:0]   fill_value;
    logic               image_done;
  } result_t;

endpackage

// ----- rtl/qtd_cell.sv -----
`timescale 1ns / 1ps

// One stack entry. Cell 0 is the top of the stack. On each update the
// entry either takes a freshly pushed quadrant or the entry that sat
// (shift - 1) places nearer the top.
module qtd_cell #(
  parameter int RW  = 40,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  qtd_pkg::cell_ctl_t ctl,
  input  logic [RW-1:0]     load,
  input  logic [RW-1:0]     nb_up,    // cell IDX+1
  input  logic [RW-1:0]     nb_same,  // cell IDX
  input  logic [RW-1:0]     nb_dn1,   // cell IDX-1
  input  logic [RW-1:0]     nb_dn2,   // cell IDX-2
  input  logic [RW-1:0]     nb_dn3,   // cell IDX-3
  output logic [RW-1:0]     region
);

  logic [RW-1:0] region_next;

  always_comb begin
    if (IDX < int'(ctl.shift)) begin
      region_next = load;
    end else begin
      unique case (ctl.shift)
        3'd0:    region_next = nb_up;
        3'd1:    region_next = nb_same;
        3'd2:    region_next = nb_dn1;
        3'd3:    region_next = nb_dn2;
        3'd4:    region_next = nb_dn3;
        default: region_next = nb_same;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      region <= region_next;
    end
  end

endmodule

// ----- rtl/qtd_out_buf.sv -----
`timescale 1ns / 1ps
`include "quadtree_image_decoder_top_assert.svh"

// Two-entry result buffer: output register plus skid slot.
module qtd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qtd_pkg::result_t push_data,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output qtd_pkg::result_t out_data
);

  logic             main_valid;
  logic             skid_valid;
  qtd_pkg::result_t skid_data;
  logic             main_load;

  assign space_ok  = !skid_valid;
  assign out_valid = main_valid;
  assign main_load = !main_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_load) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_load) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  `QTD_ASSERT_IMPL(a_skid_behind_main, clk, rst, skid_valid, main_valid, "skid holds data ahead of output")
  `QTD_ASSERT_NEXT(a_stall_fills_skid, clk, rst, push && main_valid && !out_ready, skid_valid, "stalled request lost")
  `QTD_ASSERT_IMPL(a_no_push_when_full, clk, rst, skid_valid, !push, "request pushed into full buffer")

endmodule

// ----- rtl/quadtree_image_decoder_top.sv -----
`timescale 1ns / 1ps
`include "quadtree_image_decoder_top_assert.svh"

// Quadtree image decoder.
// Input channel (in_valid/in_ready, symbol): one code character per request.
//   '*' splits the pending region into its non-empty quadrants, '0'..'9' are
//   skipped, anything else is a leaf that fills the next pending region.
// Output channel (out_valid/out_ready): one rectangle per leaf, with the
//   fill character and image_done set on the leaf that empties the stack.
// Config: cfg_we/cfg_data write side_length; it is sampled when a new image
//   starts (0 acts as 1, values above MAX_SIDE act as MAX_SIDE).
// Throughput: one request per cycle while in_ready is high. The pending stack is a chain of cells
//   that pops one entry and pushes up to four in the same cycle.
// Output path: an accepted leaf is registered in the output register, or in the skid slot on a stall.
// Stall: the output register plus a skid slot absorb one extra result;
//   in_ready drops only while the skid slot is full.
// Reset: empty stack, no image active, side_length = 1024, no output.
// Quadrants beyond STACK_DEPTH pending entries are dropped.
module quadtree_image_decoder_top #(
  parameter int MAX_SIDE    = 1024,
  parameter int STACK_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qtd_pkg::SIDE_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [qtd_pkg::SYM_W-1:0]       symbol,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [qtd_pkg::COORD_W-1:0]     row_top,
  output logic [qtd_pkg::COORD_W-1:0]     col_left,
  output logic [qtd_pkg::COORD_W-1:0]     row_bottom,
  output logic [qtd_pkg::COORD_W-1:0]     col_right,
  output logic [qtd_pkg::SYM_W-1:0]       fill_value,
  output logic                            image_done
);

  localparam int CW   = $clog2(MAX_SIDE);          // coordinate width
  localparam int RW   = 4 * CW;                    // {top, left, bottom, right}
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int SW   = (CW + 1 > qtd_pkg::SIDE_W) ? CW + 1 : qtd_pkg::SIDE_W;
  localparam int OW   = qtd_pkg::COORD_W;

  logic [qtd_pkg::SIDE_W-1:0] side_length;
  logic [CNTW-1:0]            count;

  logic [RW-1:0] regs [STACK_DEPTH];
  logic [RW-1:0] pad  [STACK_DEPTH + 4];
  logic [RW-1:0] new_top [4];
  logic [RW-1:0] ne [4];

  qtd_pkg::cell_ctl_t ctl;
  qtd_pkg::result_t   res;
  qtd_pkg::result_t   out_data;

  logic            acc, is_digit, is_split, leaf_push, start, space_ok;
  logic [SW-1:0]   side_w, side_eff;
  logic [CW-1:0]   last;
  logic [RW-1:0]   cur;
  logic [CW-1:0]   t, l, b, r, mr, mc, mr1, mc1;
  logic [CW:0]     sum_r, sum_c;
  logic            has_tr, has_bl;
  logic [2:0]      n_quad, m_push, drop;
  logic [CNTW-1:0] cnt_after;
  logic [CNTW:0]   space, m_wide;
  logic [CNTW:0]   count_next_w;

  // ---------------- head of stack: pop and split ----------------
  always_comb begin
    is_digit = (symbol >= qtd_pkg::DIGIT_LO) && (symbol <= qtd_pkg::DIGIT_HI);
    is_split = (symbol == qtd_pkg::SPLIT_CHAR);
    acc      = in_valid && in_ready;
    start    = (count == '0);

    side_w = SW'(side_length);
    if (side_w == '0) begin
      side_eff = SW'(1);
    end else if (side_w > SW'(MAX_SIDE)) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = side_w;
    end
    last = CW'(side_eff - SW'(1));

    // a new image starts from the whole square
    cur       = start ? {{(2 * CW){1'b0}}, last, last} : regs[0];
    cnt_after = start ? '0 : count - CNTW'(1);

    t = cur[4*CW-1 -: CW];
    l = cur[3*CW-1 -: CW];
    b = cur[2*CW-1 -: CW];
    r = cur[CW-1 -: CW];

    sum_r = {1'b0, t} + {1'b0, b};
    sum_c = {1'b0, l} + {1'b0, r};
    mr    = sum_r[CW:1];
    mc    = sum_c[CW:1];
    mr1   = mr + CW'(1);
    mc1   = mc + CW'(1);

    has_tr = (mc < r);
    has_bl = (mr < b);
    n_quad = 3'd1 + {2'b0, has_tr} + {2'b0, has_bl} + {2'b0, has_tr && has_bl};

    // non-empty quadrants in top-first order
    ne[0] = {t, l, mr, mc};
    ne[1] = has_tr ? {t, mc1, mr, r} : {mr1, l, b, mc};
    ne[2] = {mr1, l, b, mc};
    ne[3] = {mr1, mc1, b, r};

    // only the deepest quadrants fit when the stack is nearly full
    space  = (CNTW + 1)'(STACK_DEPTH) - {1'b0, cnt_after};
    m_wide = ((CNTW + 1)'(n_quad) < space) ? (CNTW + 1)'(n_quad) : space;
    m_push = is_split ? 3'(m_wide) : 3'd0;
    drop   = n_quad - m_push;

    for (int j = 0; j < 4; j++) begin
      new_top[j] = ne[2'(j + int'(drop))];
    end

    count_next_w = {1'b0, cnt_after} + (CNTW + 1)'(m_push);

    leaf_push = acc && !is_digit && !is_split;
    ctl.en    = acc && !is_digit;
    ctl.shift = m_push;

    res.row_top    = OW'(t);
    res.col_left   = OW'(l);
    res.row_bottom = OW'(b);
    res.col_right  = OW'(r);
    res.fill_value = symbol;
    res.image_done = (cnt_after == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= qtd_pkg::SIDE_RESET;
      count       <= '0;
    end else begin
      if (cfg_we) begin
        side_length <= cfg_data;
      end
      if (ctl.en) begin
        count <= CNTW'(count_next_w);
      end
    end
  end

  // ---------------- stack cell chain ----------------
  // pad[k] = regs[k-3]; out-of-range neighbors read as zero
  always_comb begin
    for (int k = 0; k < STACK_DEPTH + 4; k++) begin
      pad[k] = '0;
    end
    for (int k = 0; k < STACK_DEPTH; k++) begin
      pad[k + 3] = regs[k];
    end
  end

  for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
    logic [RW-1:0] load_j;
    if (j < 4) begin : g_load
      assign load_j = new_top[j];
    end else begin : g_noload
      assign load_j = '0;
    end

    qtd_cell #(
      .RW  (RW),
      .IDX (j)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .load    (load_j),
      .nb_up   (pad[j + 4]),
      .nb_same (pad[j + 3]),
      .nb_dn1  (pad[j + 2]),
      .nb_dn2  (pad[j + 1]),
      .nb_dn3  (pad[j]),
      .region  (regs[j])
    );
  end

  // ---------------- result buffer ----------------
  qtd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (leaf_push),
    .push_data (res),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready   = space_ok;
  assign row_top    = out_data.row_top;
  assign col_left   = out_data.col_left;
  assign row_bottom = out_data.row_bottom;
  assign col_right  = out_data.col_right;
  assign fill_value = out_data.fill_value;
  assign image_done = out_data.image_done;

  `QTD_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNTW'(STACK_DEPTH), "stack count overflow")
  `QTD_ASSERT_NEXT(a_split_keeps_image, clk, rst, acc && is_split, count != '0, "split left empty stack")
  `QTD_ASSERT_NEXT(a_done_empties, clk, rst, leaf_push && res.image_done, count == '0, "image done but regions pending")
  `QTD_ASSERT_NEXT(a_not_done_pending, clk, rst, leaf_push && !res.image_done, count != '0, "stack empty without image done")

endmodule
